>>> sv/mdds_pkg.sv
// Shared types, constants and waveform tables for the multichannel DDS generator.
`default_nettype none

package mdds_pkg;

  localparam int unsigned NUM_SETUPS   = 4;
  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned SETUP_W      = 51;
  localparam int unsigned CH_W         = 2;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned PHASE_W      = 32;
  localparam int unsigned COUNT_W      = 32;

  localparam logic [SAMPLE_W-1:0] MIDSCALE = 16'h8000;

  // Waveform shape codes held in setup bits 49:48.
  localparam logic [1:0] SHAPE_SINE     = 2'd0;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [1:0] SHAPE_SAWTOOTH = 2'd2;
  localparam logic [1:0] SHAPE_UNKNOWN  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MUL,
    ST_OUT
  } seq_state_e;

  // Step strobes from the sequencer to the datapath.
  typedef struct packed {
    logic            load;
    logic            mul;
    logic            emit;
    logic            last;
    logic [CH_W-1:0] ch;
  } seq_ctrl_t;

  typedef logic [SAMPLE_W-1:0] wave_rom_t [TABLE_DEPTH];

  localparam logic [63:0] PI_F_MANT   = 64'd13176795;
  localparam logic [63:0] ONE_Q60     = 64'h1000000000000000;
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  // The functions below only build constant tables during elaboration.
  function automatic int unsigned top_bit(logic [63:0] v);
    int unsigned b;
    b = 0;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) b = k;
    end
    return b;
  endfunction

  // Round to 24 significant bits, ties to even.
  function automatic logic [63:0] round24(logic [63:0] v);
    int unsigned b;
    int unsigned sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    if (v == 64'd0) return 64'd0;
    b = top_bit(v);
    if (b <= 23) return v;
    sh   = b - 23;
    q    = v >> sh;
    rem  = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q << sh;
  endfunction

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[123:60];
  endfunction

  // Unsigned quotient by shift and subtract, one quotient bit per step.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [15:0] sine_entry(int unsigned i);
    logic [63:0] x;
    logic [63:0] y2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] sum;
    logic [63:0] a;
    logic [63:0] p;
    logic [63:0] dv;
    int unsigned b;
    int unsigned sh;
    logic neg;
    neg = 1'b0;
    x = round24(PI_F_MANT * 64'(i)) << 31;
    if (x > PI_Q60) begin
      x   = TWO_PI_Q60 - x;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q60) x = PI_Q60 - x;
    y2 = mul_q60(x, x);
    t  = x;
    s  = x;
    for (int k = 1; k <= 13; k++) begin
      dv = 64'((2 * k) * (2 * k + 1));
      t  = div_u64(mul_q60(t, y2), dv);
      if ((k % 2) == 1) s = s - t;
      else s = s + t;
    end
    m = round24(s);
    if (m > ONE_Q60) m = ONE_Q60;
    sum = neg ? ONE_Q60 - m : ONE_Q60 + m;
    a = round24(sum);
    if (a == 64'd0) return 16'd0;
    b  = top_bit(a);
    sh = (b > 23) ? b - 23 : 0;
    p  = round24((a >> sh) * 64'd65535);
    p  = p >> (61 - sh);
    return (p > 64'd65535) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic wave_rom_t build_sine_rom();
    wave_rom_t r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      r[i] = sine_entry(i);
    end
    return r;
  endfunction

  function automatic wave_rom_t build_triangle_rom();
    wave_rom_t r;
    int unsigned v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i < TABLE_DEPTH / 2) v = (i * 65535) / (TABLE_DEPTH / 2);
      else v = ((TABLE_DEPTH - i) * 65535) / (TABLE_DEPTH / 2);
      r[i] = v[15:0];
    end
    return r;
  endfunction

  localparam wave_rom_t SINE_ROM     = build_sine_rom();
  localparam wave_rom_t TRIANGLE_ROM = build_triangle_rom();

endpackage

`default_nettype wire

>>> sv/mdds_scaler.sv
// Shared amplitude scaler: one signed multiply, then truncation toward zero, or a bypass of the raw sample.
`default_nettype none

module mdds_scaler
  import mdds_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                start_i,
  input  wire logic                bypass_i,
  input  wire logic [SAMPLE_W-1:0] raw_i,
  input  wire logic [14:0]         amp_i,
  output      logic [SAMPLE_W-1:0] sample_o
);

  logic signed [16:0] offset;
  logic signed [15:0] amp_s;
  logic signed [31:0] prod_d, prod_q;
  logic signed [31:0] adj;
  logic               bypass_q;
  logic [SAMPLE_W-1:0] raw_q;

  assign offset = $signed({1'b0, raw_i}) - $signed({1'b0, MIDSCALE});
  assign amp_s  = $signed({1'b0, amp_i});
  assign prod_d = 32'(offset * amp_s);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q   <= prod_d;
      bypass_q <= bypass_i;
      raw_q    <= raw_i;
    end
  end

  // A negative product is biased so the arithmetic shift rounds toward zero.
  assign adj = prod_q[31] ? prod_q + 32'sd32767 : prod_q;

  always_comb begin
    if (bypass_q) begin
      sample_o = raw_q;
    end else begin
      sample_o = 16'(adj[30:15] + MIDSCALE);
    end
  end

endmodule

`default_nettype wire

>>> sv/mdds_seq.sv
// Sequencer that walks the channels through lookup, multiply and output steps.
`default_nettype none

module mdds_seq
  import mdds_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic out_free_i,
  output      logic idle_o,
  output seq_ctrl_t ctrl_o
);

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  seq_state_e      state_q, state_d;
  logic [CH_W-1:0] ch_q, ch_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    idle_o      = 1'b0;
    ctrl_o.load = 1'b0;
    ctrl_o.mul  = 1'b0;
    ctrl_o.emit = 1'b0;
    ctrl_o.last = (ch_q == LAST_CH);
    ctrl_o.ch   = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          ch_d    = '0;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        ctrl_o.load = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        ctrl_o.mul = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          ctrl_o.emit = 1'b1;
          if (ch_q == LAST_CH) begin
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_LOOKUP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/multichannel_dds_wave_generator.sv
// Top level of the multichannel DDS wave generator: setup registers, channel state, result port.
//
//   Channel  Direction  Beat contents
//   s_axis   in         tdata[0] sample tick (bits 7:1 zero)
//   m_axis   out        tuser channel index, tdata sample/phase/count, tlast last channel
//   cfg      in         cfg_index_i register number, cfg_data_i 51-bit channel setup
//
// Each channel goes through the phase add with waveform lookup, the shared
// multiply, and the output load, in that order. A tick beat is taken only
// in the idle state, so the next tick waits until every channel is through,
// including any wait for the result register to drain. The single scaler
// multiplier is what the channels take turns on. Reset clears the accumulators
// and sample counters and restores every setup to its default. A stalled
// result port holds the sequencer in its output step; the tick port is ready
// only while idle.
`default_nettype none

module multichannel_dds_wave_generator
  import mdds_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Tick input.
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [0] sample_tick
  // Result output.
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [79:0]        m_axis_tdata,   // [15:0] sample_value, [47:16] phase_value,
                                                  // [79:48] sample_total
  output      logic [CH_W-1:0]    m_axis_tuser,   // [1:0] channel_index
  output      logic               m_axis_tlast,   // last_of_tick
  // Setup register writes.
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [SETUP_W-1:0] cfg_data_i
);

  localparam logic [SETUP_W-1:0] SETUP_RESET = 51'd89478485;

  logic [SETUP_W-1:0] setup_q [NUM_SETUPS];
  logic [PHASE_W-1:0] acc_q   [NUM_SETUPS];
  logic [COUNT_W-1:0] cnt_q   [NUM_SETUPS];

  seq_ctrl_t ctrl;
  logic      idle;
  logic      out_free;
  logic      tick_start;

  // The user must issue setup writes only while the block is idle; unchecked, all are taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SETUPS; i++) setup_q[i] <= SETUP_RESET;
    end else if (cfg_valid_i) begin
      setup_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // A beat whose tick bit is clear is consumed without producing anything.
  assign s_axis_tready = idle;
  assign tick_start    = s_axis_tvalid && s_axis_tdata[0];

  assign out_free = !m_axis_tvalid || m_axis_tready;

  mdds_seq #(
    .CHANNELS(CHANNELS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (tick_start),
    .out_free_i(out_free),
    .idle_o    (idle),
    .ctrl_o    (ctrl)
  );

  // Lookup step: decode the setup of the current channel, advance its phase
  // and pick the raw sample from the top eight phase bits.
  logic [SETUP_W-1:0]  setup_cur;
  logic [PHASE_W-1:0]  inc;
  logic [15:0]         amp;
  logic [1:0]          shape;
  logic                enable;
  logic [PHASE_W-1:0]  acc_next;
  logic [7:0]          idx;
  logic [SAMPLE_W-1:0] raw_d, raw_q;
  logic                bypass_d, bypass_q;
  logic [14:0]         amp_q;

  assign setup_cur = setup_q[ctrl.ch];
  assign inc       = setup_cur[31:0];
  assign amp       = setup_cur[47:32];
  assign shape     = setup_cur[49:48];
  assign enable    = setup_cur[50];
  assign acc_next  = acc_q[ctrl.ch] + inc;
  assign idx       = acc_next[31:24];

  always_comb begin
    raw_d = MIDSCALE;
    if (enable) begin
      unique case (shape)
        SHAPE_SINE:     raw_d = SINE_ROM[idx];
        SHAPE_TRIANGLE: raw_d = TRIANGLE_ROM[idx];
        SHAPE_SAWTOOTH: raw_d = {idx, idx};
        SHAPE_UNKNOWN:  raw_d = MIDSCALE;
        default:        raw_d = MIDSCALE;
      endcase
    end
  end

  // Amplitudes at or above unity pass the sample through unchanged, and so
  // does a disabled channel, whose raw sample is already midscale.
  assign bypass_d = !enable || amp[15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SETUPS; i++) begin
        acc_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (ctrl.load && enable) begin
      acc_q[ctrl.ch] <= acc_next;
      cnt_q[ctrl.ch] <= cnt_q[ctrl.ch] + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      raw_q    <= raw_d;
      bypass_q <= bypass_d;
      amp_q    <= amp[14:0];
    end
  end

  logic [SAMPLE_W-1:0] sample;

  mdds_scaler u_scaler (
    .clk_i   (clk_i),
    .start_i (ctrl.mul),
    .bypass_i(bypass_q),
    .raw_i   (raw_q),
    .amp_i   (amp_q),
    .sample_o(sample)
  );

  // Result register: one beat waits here while the next channel is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      m_axis_tdata <= {cnt_q[ctrl.ch], acc_q[ctrl.ch], sample};
      m_axis_tuser <= ctrl.ch;
      m_axis_tlast <= ctrl.last;
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the four-channel DDS wave generator, with its own channel model.
`timescale 1ns / 100ps

module tb_top;
  import mdds_pkg::*;

  // The bench models the default build with all four channels.
  localparam int unsigned NCH = CHANNELS_DEF;

  // DRAIN_CYCLES covers any work still under way after the last result beat,
  // including a tick that yields nothing.
  localparam int unsigned DRAIN_CYCLES = 40;
  // The result side holds off this long once, which is enough to back the
  // block up into its tick port.
  localparam int unsigned RX_HOLD_CYCLES = 300;
  // Cycles in a row without any accepted beat before the run is declared hung.
  // The longest legitimate quiet stretch is the hold-off above.
  localparam int unsigned STALL_LIMIT = 2000;

  // Fixed-point constants for the sine table: single-precision pi as a
  // mantissa, and pi-related values in Q60.
  localparam logic [63:0] PI_MANT_F32 = 64'd13176795;
  localparam logic [63:0] Q60_ONE     = 64'h1000000000000000;
  localparam logic [63:0] Q60_PI      = 64'h3243F6A8885A308D;
  localparam logic [63:0] Q60_TWO_PI  = 64'h6487ED5110B4611A;
  localparam logic [63:0] Q60_HALF_PI = 64'h1921FB54442D1846;

  // One result beat as the block should produce it.
  typedef struct {
    logic [CH_W-1:0]     chan;
    logic [SAMPLE_W-1:0] sample;
    logic [PHASE_W-1:0]  phase;
    logic [COUNT_W-1:0]  total;
    logic                last;
  } dds_sample_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'd0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [79:0]         m_axis_tdata;
  logic [CH_W-1:0]     m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = 2'd0;
  logic [SETUP_W-1:0]  cfg_data_i = '0;

  // Model state: the setup registers as written, and each channel's phase
  // accumulator and sample counter.
  logic [SETUP_W-1:0]  chan_setup [NCH];
  logic [PHASE_W-1:0]  chan_phase [NCH];
  logic [COUNT_W-1:0]  chan_count [NCH];
  logic [SAMPLE_W-1:0] sine_tab [TABLE_DEPTH];

  dds_sample_t         expected_samples [$];
  dds_sample_t         want_beat;
  int                  mismatches = 0;
  bit                  gaps_on = 1'b1;
  bit                  rx_hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  multichannel_dds_wave_generator #(
    .CHANNELS(NCH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] sample_tick, [7:1] zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] sample, [47:16] phase, [79:48] total
    .m_axis_tuser  (m_axis_tuser),   // [1:0] channel index
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Sine table arithmetic. The table is the single-precision formula evaluated
  // exactly: a Taylor series in Q60 with the angle, the sum and the scaling steps
  // rounded to 24 significant bits, ties to even.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rnd24(logic [63:0] v);
    int          msb;
    int          sh;
    logic [63:0] kept;
    logic [63:0] lost;
    logic [63:0] tie;
    msb = -1;
    for (int k = 63; k >= 0; k--) begin
      if (v[k] && msb < 0) msb = k;
    end
    if (msb <= 23) return v;
    sh   = msb - 23;
    kept = v >> sh;
    lost = v & ((64'd1 << sh) - 64'd1);
    tie  = 64'd1 << (sh - 1);
    if (lost > tie || (lost == tie && kept[0])) kept = kept + 64'd1;
    return kept << sh;
  endfunction

  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  function automatic logic [15:0] sine_point(int unsigned i);
    logic [63:0] x;
    logic [63:0] sq;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] mag;
    logic [63:0] biased;
    logic [63:0] p;
    int          msb;
    int          sh;
    bit          neg;
    neg = 1'b0;
    x = rnd24(PI_MANT_F32 * 64'(i)) << 31;
    // Fold the angle into the first quadrant, remembering the sign.
    if (x > Q60_PI) begin
      x   = Q60_TWO_PI - x;
      neg = 1'b1;
    end
    if (x > Q60_HALF_PI) x = Q60_PI - x;
    sq   = q60_mul(x, x);
    term = x;
    acc  = x;
    for (int k = 1; k <= 13; k++) begin
      term = q60_mul(term, sq) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    mag = rnd24(acc);
    if (mag > Q60_ONE) mag = Q60_ONE;
    biased = rnd24(neg ? Q60_ONE - mag : Q60_ONE + mag);
    if (biased == 64'd0) return 16'd0;
    msb = 0;
    for (int k = 0; k < 64; k++) begin
      if (biased[k]) msb = k;
    end
    sh = (msb > 23) ? msb - 23 : 0;
    // The 0.5 factor folds into the final shift.
    p = rnd24((biased >> sh) * 64'd65535) >> (61 - sh);
    return (p > 64'd65535) ? 16'hFFFF : p[15:0];
  endfunction

  // Raw waveform sample for one table index.
  function automatic logic [15:0] wave_point(logic [1:0] shape, logic [7:0] idx);
    int unsigned tri_val;
    case (shape)
      SHAPE_SINE: begin
        return sine_tab[idx];
      end
      SHAPE_TRIANGLE: begin
        if (idx < 8'd128) tri_val = (int'(idx) * 65535) / 128;
        else tri_val = ((256 - int'(idx)) * 65535) / 128;
        return tri_val[15:0];
      end
      SHAPE_SAWTOOTH: begin
        return 16'(int'(idx) * 257);
      end
      default: begin
        return MIDSCALE;
      end
    endcase
  endfunction

  // One tick: every channel in order yields one result beat. Enabled channels
  // step their phase, look up the wave and scale it around midscale; an
  // amplitude of unity or more passes the sample through untouched.
  function automatic void advance_channels();
    logic [SETUP_W-1:0]  s;
    logic [15:0]         amp;
    logic [SAMPLE_W-1:0] raw;
    int                  d;
    dds_sample_t         r;
    for (int ch = 0; ch < NCH; ch++) begin
      s   = chan_setup[ch];
      amp = s[47:32];
      raw = MIDSCALE;
      if (s[50]) begin
        chan_phase[ch] = chan_phase[ch] + s[31:0];
        raw = wave_point(s[49:48], chan_phase[ch][31:24]);
        if (amp < 16'h8000) begin
          // Signed division truncates toward zero, as the scaler does.
          d   = (int'(raw) - 32768) * int'(amp);
          d   = d / 32768;
          raw = 16'(d + 32768);
        end
        chan_count[ch] = chan_count[ch] + 32'd1;
      end
      r.chan   = CH_W'(ch);
      r.sample = raw;
      r.phase  = chan_phase[ch];
      r.total  = chan_count[ch];
      r.last   = (ch == NCH - 1);
      expected_samples.push_back(r);
    end
  endfunction

  function automatic logic [SETUP_W-1:0] make_setup(logic en, logic [1:0] shape,
                                                    logic [15:0] amp, logic [31:0] inc);
    return {en, shape, amp, inc};
  endfunction

  // Random setups lean toward enabled channels and toward the amplitude
  // boundaries around unity, where the scaler changes behavior.
  function automatic logic [SETUP_W-1:0] random_setup();
    logic [31:0] inc;
    logic [15:0] amp;
    case ($urandom_range(3))
      0: inc = $urandom_range(0, 32'h0400_0000);
      1: inc = 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
      default: inc = $urandom;
    endcase
    case ($urandom_range(5))
      0: amp = 16'h8000;
      1: amp = 16'($urandom_range(16'h8001, 16'hFFFF));
      2: amp = 16'($urandom_range(0, 16'h7FFF));
      3: amp = ($urandom_range(1) == 1) ? 16'h7FFF : 16'h0000;
      default: amp = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return make_setup($urandom_range(99) < 80, 2'($urandom_range(3)), amp, inc);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Every accepted result beat is compared against the oldest
  // outstanding prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $error("result beat for channel %0d arrived with nothing expected", m_axis_tuser);
        mismatches++;
      end else begin
        want_beat = expected_samples.pop_front();
        check_field("channel_index", 32'(want_beat.chan), 32'(m_axis_tuser));
        check_field("sample_value", 32'(want_beat.sample), 32'(m_axis_tdata[15:0]));
        check_field("phase_value", want_beat.phase, m_axis_tdata[47:16]);
        check_field("sample_total", want_beat.total, m_axis_tdata[79:48]);
        check_field("last_of_tick", 32'(want_beat.last), 32'(m_axis_tlast));
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request that
  // this process counts out itself.
  initial begin : result_sink
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= !(gaps_on && $urandom_range(99) < 32);
    end
  end

  // Hang detection: a run of quiet cycles, in which no beat moves on any port and
  // reset is off, is counted against STALL_LIMIT and ends the run as failed.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one tick beat, with random idle cycles ahead of it, and updates the
  // model once the beat is accepted. Valid stays high afterwards so that the
  // next call can follow back to back; hold_ticks lowers it.
  task automatic send_tick(input logic tick);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, tick};
    do @(posedge clk_i); while (!s_axis_tready);
    // A zero tick is accepted but ignored by the block.
    if (tick) advance_channels();
  endtask

  task automatic hold_ticks();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits for every predicted beat, then lets any trailing work finish so the
  // block is idle before the setups change.
  task automatic wait_quiet();
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_setup(input logic [1:0] idx, input logic [SETUP_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    chan_setup[idx] = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset setups leave every channel disabled, so each beat carries midscale
  // and the cleared state. The zero tick in between must produce nothing.
  task automatic test_reset_state();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    hold_ticks();
    wait_quiet();
  endtask

  // Each shape once, with unity, saturating and partial amplitudes and the
  // largest phase step; then the all-ones and all-zeros setups, zero
  // amplitude and the largest amplitude just below unity.
  task automatic test_waveforms();
    write_setup(2'd0, make_setup(1'b1, SHAPE_SINE, 16'h8000, 32'h0100_0000));
    write_setup(2'd1, make_setup(1'b1, SHAPE_TRIANGLE, 16'hFFFF, 32'hFFFF_FFFF));
    write_setup(2'd2, make_setup(1'b1, SHAPE_SAWTOOTH, 16'h4000, 32'h8000_0000));
    write_setup(2'd3, make_setup(1'b1, SHAPE_UNKNOWN, 16'h8000, 32'h0123_4567));
    repeat (6) send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    hold_ticks();
    wait_quiet();

    write_setup(2'd0, {SETUP_W{1'b1}});
    // Channel 1 goes disabled and must report its held phase and count.
    write_setup(2'd1, '0);
    write_setup(2'd2, make_setup(1'b1, SHAPE_SINE, 16'h0000, 32'h0400_0000));
    write_setup(2'd3, make_setup(1'b1, SHAPE_TRIANGLE, 16'h7FFF, 32'h0200_0000));
    repeat (5) send_tick(1'b1);
    hold_ticks();
    wait_quiet();
  endtask

  // Random setups over several phases; one phase runs with no idle cycles on
  // either side. About one tick in ten is a zero tick.
  task automatic test_random_settings();
    int unsigned calm_phase;
    calm_phase = $urandom_range(3);
    for (int phase = 0; phase < 4; phase++) begin
      for (int ch = 0; ch < NCH; ch++) write_setup(2'(ch), random_setup());
      gaps_on = (phase != calm_phase);
      repeat (22) send_tick($urandom_range(99) >= 10);
      hold_ticks();
      wait_quiet();
    end
    gaps_on = 1'b1;
  endtask

  // The result side stops for a long while as ticks keep coming, so the block
  // fills up and has to stall its tick port.
  task automatic test_backpressure();
    for (int ch = 0; ch < NCH; ch++) write_setup(2'(ch), random_setup());
    rx_hold_req = 1'b1;
    repeat (10) send_tick(1'b1);
    hold_ticks();
    wait_quiet();
  endtask

  // The tick side pauses until every outstanding beat has been delivered, then
  // picks up again with the same setups.
  task automatic test_drain_pause();
    repeat (4) send_tick(1'b1);
    hold_ticks();
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (4) send_tick(1'b1);
    hold_ticks();
    wait_quiet();
  endtask

  initial begin : main
    for (int i = 0; i < TABLE_DEPTH; i++) sine_tab[i] = sine_point(i);
    // Reset value of every setup is 0x05555555: disabled, sine, zero amplitude.
    for (int ch = 0; ch < NCH; ch++) begin
      chan_setup[ch] = SETUP_W'(32'h0555_5555);
      chan_phase[ch] = '0;
      chan_count[ch] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_waveforms();
    test_random_settings();
    test_backpressure();
    test_drain_pause();

    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
